FILE: sv/frv_pkg.sv
// ----------------------------------------------------------------------------
// frv_pkg
// Shared types, codes and helper functions for the framed record validator.
// ----------------------------------------------------------------------------
package frv_pkg;

  localparam int HDR_BYTES  = 48;
  localparam int TRL_BYTES  = 4;
  localparam int NUM_FIELDS = 13;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  // Item kinds
  localparam logic [1:0] KIND_GRID   = 2'd0;
  localparam logic [1:0] KIND_BLOCK  = 2'd1;
  localparam logic [1:0] KIND_FIELD  = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_MAGIC    = 3'd2;
  localparam logic [2:0] ST_VERSION  = 3'd3;
  localparam logic [2:0] ST_IQ_FMT   = 3'd4;
  localparam logic [2:0] ST_GRID_LEN = 3'd5;
  localparam logic [2:0] ST_TRUNC    = 3'd6;
  localparam logic [2:0] ST_CRC      = 3'd7;

  // Header field ids that drive checks or state
  localparam logic [3:0] FLD_VERSION  = 4'd0;
  localparam logic [3:0] FLD_IQ       = 4'd1;
  localparam logic [3:0] FLD_PRB      = 4'd3;
  localparam logic [3:0] FLD_SYMBOLS  = 4'd4;
  localparam logic [3:0] FLD_TB_LEN   = 4'd7;
  localparam logic [3:0] FLD_GRID_LEN = 4'd12;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_EXP_VERSION = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_EXP_IQ      = 1'b1;

  // Header field layout: start byte and length
  localparam logic [5:0] FLD_START [NUM_FIELDS] =
    '{6'd4, 6'd6, 6'd7, 6'd8, 6'd10, 6'd11, 6'd12, 6'd16, 6'd24, 6'd28, 6'd32, 6'd36, 6'd40};
  localparam logic [3:0] FLD_LEN [NUM_FIELDS] =
    '{4'd2, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd2, 4'd8, 4'd4, 4'd4, 4'd4, 4'd4, 4'd8};

  typedef struct packed {
    logic       is_fld;
    logic [3:0] id;
    logic [2:0] k;
    logic       last;
  } frv_fmap_t;

  // One queue entry: an optional field/payload item and an optional status item
  typedef struct packed {
    logic        a_vld;
    logic [1:0]  a_kind;
    logic [3:0]  a_id;
    logic [63:0] a_val;
    logic        b_vld;
    logic [2:0]  b_status;
  } frv_entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  id;
    logic [63:0] value;
    logic [2:0]  status;
    logic        last;
  } frv_item_t;

  function automatic frv_fmap_t field_map(input logic [5:0] pos);
    frv_fmap_t  m;
    logic [5:0] off;
    m   = '0;
    off = '0;
    for (int f = 0; f < NUM_FIELDS; f++) begin
      off = pos - FLD_START[f];
      if (pos >= FLD_START[f] && off < 6'(FLD_LEN[f])) begin
        m.is_fld = 1'b1;
        m.id     = 4'(f);
        m.k      = off[2:0];
        m.last   = (off == 6'(FLD_LEN[f] - 4'd1));
      end
    end
    return m;
  endfunction

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h4F;
      2'd1:    m = 8'h53;
      2'd2:    m = 8'h47;
      default: m = 8'h31;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

FILE: sv/frv_parser.sv
// ----------------------------------------------------------------------------
// frv_parser
// Per-byte record state: position, CRC, header field assembly, region
// bounds, error tracking and final status. Builds at most one queue entry per byte.
// ----------------------------------------------------------------------------
module frv_parser #(
  parameter int COUNT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [7:0]          data_byte,
  input  logic                end_of_record,
  input  logic [15:0]         exp_version,
  input  logic [7:0]          exp_iq_format,
  output frv_pkg::frv_entry_t entry,
  output logic                entry_vld
);
  import frv_pkg::*;

  localparam logic [63:0] CMAX64 = {64{1'b1}} >> (64 - COUNT_BITS);
  localparam logic [COUNT_BITS-1:0] PMAX = '1;

  logic [COUNT_BITS-1:0] pos_r, pos_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [15:0] prb_r, prb_nxt;
  logic [7:0]  sym_r, sym_nxt;
  logic [23:0] prod_r;
  logic [29:0] grid_exp_r;
  logic [63:0] blk48_r, blk48_nxt, blk52_r, blk52_nxt;
  logic [63:0] grid_end_r, grid_end_nxt, crc_off_r, crc_off_nxt;
  logic [63:0] need_m1_r, need_m1_nxt;
  logic        need_big_r, need_big_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [31:0] trl_r, trl_nxt, crc_trl_r, crc_trl_nxt;

  logic [63:0] p64, toff, need, acc_new;
  logic        hdr, in_grid, in_blk, in_trl, crc_on, fld_done;
  logic [2:0]  err_code, status;
  frv_fmap_t   fm;

  always_comb begin
    p64     = 64'(pos_r);
    hdr     = pos_r < COUNT_BITS'(HDR_BYTES);
    fm      = field_map(pos_r[5:0]);
    crc_on  = hdr || (p64 < crc_off_r);
    in_grid = !hdr && (p64 < grid_end_r);
    in_blk  = !hdr && !in_grid && (p64 < crc_off_r);
    toff    = p64 - crc_off_r;
    in_trl  = !hdr && !crc_on && (toff < 64'(TRL_BYTES));

    acc_new  = (fm.k == 3'd0) ? 64'(data_byte)
                              : (acc_r | (64'(data_byte) << {fm.k, 3'b000}));
    fld_done = hdr && fm.is_fld && fm.last;
    need     = sat_add(blk52_r, acc_new);

    err_code = ST_OK;
    if (hdr && pos_r < COUNT_BITS'(4) && data_byte != magic_byte(pos_r[1:0])) begin
      err_code = ST_MAGIC;
    end else if (fld_done && fm.id == FLD_VERSION && acc_new != 64'(exp_version)) begin
      err_code = ST_VERSION;
    end else if (fld_done && fm.id == FLD_IQ && acc_new != 64'(exp_iq_format)) begin
      err_code = ST_IQ_FMT;
    end else if (fld_done && fm.id == FLD_GRID_LEN && acc_new != 64'(grid_exp_r)) begin
      err_code = ST_GRID_LEN;
    end

    crc_nxt      = crc_on ? crc_byte(crc_r, data_byte) : crc_r;
    acc_nxt      = (hdr && fm.is_fld) ? acc_new : acc_r;
    prb_nxt      = prb_r;
    sym_nxt      = sym_r;
    blk48_nxt    = blk48_r;
    blk52_nxt    = blk52_r;
    grid_end_nxt = grid_end_r;
    crc_off_nxt  = crc_off_r;
    need_m1_nxt  = need_m1_r;
    need_big_nxt = need_big_r;
    err_nxt      = (err_r == ST_OK) ? err_code : err_r;
    trl_nxt      = trl_r;
    crc_trl_nxt  = crc_trl_r;

    if (fld_done) begin
      case (fm.id)
        FLD_PRB:     prb_nxt = acc_new[15:0];
        FLD_SYMBOLS: sym_nxt = acc_new[7:0];
        FLD_TB_LEN: begin
          blk48_nxt = sat_add(64'(HDR_BYTES), acc_new);
          blk52_nxt = sat_add(64'(HDR_BYTES + TRL_BYTES), acc_new);
        end
        FLD_GRID_LEN: begin
          grid_end_nxt = sat_add(64'(HDR_BYTES), acc_new);
          crc_off_nxt  = sat_add(blk48_r, acc_new);
          need_big_nxt = need > CMAX64;
          need_m1_nxt  = need - 64'd1;
        end
        default: ;
      endcase
    end

    if (in_trl) begin
      if (toff[1:0] == 2'd0) begin
        crc_trl_nxt = ~crc_r;
        trl_nxt     = 32'(data_byte);
      end else begin
        trl_nxt = trl_r | (32'(data_byte) << {toff[1:0], 3'b000});
      end
    end

    if (pos_r < COUNT_BITS'(HDR_BYTES + TRL_BYTES - 1)) begin
      status = ST_SHORT;
    end else if (err_nxt != ST_OK) begin
      status = err_nxt;
    end else if (need_big_r || need_m1_r > p64) begin
      status = ST_TRUNC;
    end else if (trl_nxt != crc_trl_nxt) begin
      status = ST_CRC;
    end else begin
      status = ST_OK;
    end

    pos_nxt = (pos_r != PMAX) ? pos_r + COUNT_BITS'(1) : pos_r;

    if (end_of_record) begin
      pos_nxt      = '0;
      crc_nxt      = '1;
      acc_nxt      = '0;
      prb_nxt      = '0;
      sym_nxt      = '0;
      blk48_nxt    = 64'(HDR_BYTES);
      blk52_nxt    = 64'(HDR_BYTES + TRL_BYTES);
      grid_end_nxt = 64'(HDR_BYTES);
      crc_off_nxt  = 64'(HDR_BYTES);
      need_m1_nxt  = 64'(HDR_BYTES + TRL_BYTES - 1);
      need_big_nxt = 1'b0;
      err_nxt      = ST_OK;
      trl_nxt      = '0;
      crc_trl_nxt  = '0;
    end

    entry.a_vld    = fld_done || in_grid || in_blk;
    entry.a_kind   = fld_done ? KIND_FIELD : (in_grid ? KIND_GRID : KIND_BLOCK);
    entry.a_id     = fld_done ? fm.id : 4'd0;
    entry.a_val    = fld_done ? acc_new : 64'(data_byte);
    entry.b_vld    = end_of_record;
    entry.b_status = status;
    entry_vld      = entry.a_vld || entry.b_vld;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      crc_r      <= '1;
      acc_r      <= '0;
      prb_r      <= '0;
      sym_r      <= '0;
      prod_r     <= '0;
      grid_exp_r <= '0;
      blk48_r    <= 64'(HDR_BYTES);
      blk52_r    <= 64'(HDR_BYTES + TRL_BYTES);
      grid_end_r <= 64'(HDR_BYTES);
      crc_off_r  <= 64'(HDR_BYTES);
      need_m1_r  <= 64'(HDR_BYTES + TRL_BYTES - 1);
      need_big_r <= 1'b0;
      err_r      <= ST_OK;
      trl_r      <= '0;
      crc_trl_r  <= '0;
    end else begin
      // expected grid length = symbols * prb * 48, settled long before byte 47
      prod_r     <= 24'(sym_r) * 24'(prb_r);
      grid_exp_r <= (30'(prod_r) << 5) + (30'(prod_r) << 4);
      if (accept) begin
        pos_r      <= pos_nxt;
        crc_r      <= crc_nxt;
        acc_r      <= acc_nxt;
        prb_r      <= prb_nxt;
        sym_r      <= sym_nxt;
        blk48_r    <= blk48_nxt;
        blk52_r    <= blk52_nxt;
        grid_end_r <= grid_end_nxt;
        crc_off_r  <= crc_off_nxt;
        need_m1_r  <= need_m1_nxt;
        need_big_r <= need_big_nxt;
        err_r      <= err_nxt;
        trl_r      <= trl_nxt;
        crc_trl_r  <= crc_trl_nxt;
      end
    end
  end

endmodule

FILE: sv/frv_out_queue.sv
// ----------------------------------------------------------------------------
// frv_out_queue
// Two-entry result queue. Each entry carries up to two items, sent in order.
// ----------------------------------------------------------------------------
module frv_out_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  frv_pkg::frv_entry_t wr_entry,
  output logic                can_accept,
  output frv_pkg::frv_item_t  item,
  output logic                item_vld,
  input  logic                item_rdy
);
  import frv_pkg::*;

  frv_entry_t q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       sub_r, sub_nxt;
  frv_entry_t head;
  logic       show_a, xfer, pop;

  always_comb begin
    head       = q_r[rd_ptr_r];
    item_vld   = cnt_r != 2'd0;
    can_accept = cnt_r != 2'd2;
    show_a     = head.a_vld && !sub_r;

    item.kind   = show_a ? head.a_kind : KIND_STATUS;
    item.id     = show_a ? head.a_id : 4'd0;
    item.value  = show_a ? head.a_val : 64'd0;
    item.status = show_a ? ST_OK : head.b_status;
    item.last   = !show_a;

    xfer    = item_vld && item_rdy;
    pop     = xfer && (!show_a || !head.b_vld);
    sub_nxt = xfer ? !pop : sub_r;
    cnt_nxt = cnt_r + {1'b0, wr_en} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
      sub_r    <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      sub_r <= sub_nxt;
      if (wr_en) wr_ptr_r <= !wr_ptr_r;
      if (pop)   rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) q_r[wr_ptr_r] <= wr_entry;
  end

endmodule

FILE: sv/framed_record_validator.sv
// ----------------------------------------------------------------------------
// framed_record_validator
// Byte-serial checker for framed records: emits header fields, tagged
// payload bytes and a final status per record.
// Each result is written into the result queue when its byte is accepted.
// Throughput: one byte per cycle while the result queue has room; the last byte
//   of a record carries up to two results, which leave through a two-entry result queue.
// Reset (rst_n, synchronous): record state cleared, queue empty, expected
//   version 1, expected IQ format 0.
// ----------------------------------------------------------------------------
module framed_record_validator #(
  parameter int COUNT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,    // [7:0] data_byte
  input  logic                          in_tlast,    // end_of_record
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [71:0]                   out_tdata,   // [63:0] field_value, [66:64] status_code
  output logic [5:0]                    out_tuser,   // [1:0] item_kind, [5:2] field_id
  output logic                          out_tlast,   // final_item
  input  logic                          cfg_wr_en,
  input  logic [frv_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [15:0]                   cfg_wr_data
);
  import frv_pkg::*;

  logic [15:0] exp_version_r;
  logic [7:0]  exp_iq_r;
  frv_entry_t  entry;
  logic        entry_vld, accept, can_accept;
  frv_item_t   item;

  assign in_tready = can_accept;
  assign accept    = in_tvalid && can_accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_version_r <= 16'd1;
      exp_iq_r      <= 8'd0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_EXP_VERSION: exp_version_r <= cfg_wr_data;
        REG_EXP_IQ:      exp_iq_r      <= cfg_wr_data[7:0];
        default: ;
      endcase
    end
  end

  frv_parser #(
    .COUNT_BITS(COUNT_BITS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .data_byte    (in_tdata),
    .end_of_record(in_tlast),
    .exp_version  (exp_version_r),
    .exp_iq_format(exp_iq_r),
    .entry        (entry),
    .entry_vld    (entry_vld)
  );

  frv_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (accept && entry_vld),
    .wr_entry  (entry),
    .can_accept(can_accept),
    .item      (item),
    .item_vld  (out_tvalid),
    .item_rdy  (out_tready)
  );

  assign out_tdata = {5'd0, item.status, item.value};
  assign out_tuser = {item.id, item.kind};
  assign out_tlast = item.last;

endmodule
